// File: rtl/tpq_pkg.sv
`timescale 1ns / 1ps
// Package for the transmit packet queue: command, status and decision codes,
// configuration register indexes, controller state type and control structs.
// No dependencies.
package tpq_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL_MS          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT_MS = 2'd2;

    localparam logic [3:0]  QUEUE_LIMIT_RESET  = 4'd8;
    localparam logic [31:0] TTL_RESET          = 32'd0;
    localparam logic [31:0] BUSY_TIMEOUT_RESET = 32'd5000;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_DECIDE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FORMAT_ERR = 2'd1;
    localparam logic [1:0] STATUS_NO_SPACE   = 2'd2;
    localparam logic [1:0] STATUS_EMPTY      = 2'd3;

    localparam logic [1:0] DECISION_SEND = 2'd0;
    localparam logic [1:0] DECISION_WAIT = 2'd1;
    localparam logic [1:0] DECISION_DROP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_RELOAD,
        ST_RELEN,
        ST_DELIVER
    } tpq_state_t;

    typedef struct packed {
        logic ready;
        logic take_item;
        logic fetch;
        logic evaluate;
        logic capture_len;
        logic deliver;
    } tpq_ctrl_t;

    typedef struct packed {
        logic is_push;
        logic is_last;
        logic pop_nonempty;
        logic out_free;
    } tpq_stat_t;

endpackage

// File: rtl/tpq_in_if.sv
`timescale 1ns / 1ps
// Request channel of the transmit packet queue: valid, ready and one command item.
// No dependencies.
interface tpq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  byte_index;
    logic [31:0] now_ms;
    logic        tx_busy;

    modport source (
        output valid, cmd, data_byte, last_byte, byte_index, now_ms, tx_busy,
        input  ready
    );
    modport sink (
        input  valid, cmd, data_byte, last_byte, byte_index, now_ms, tx_busy,
        output ready
    );
endinterface

// File: rtl/tpq_out_if.sv
`timescale 1ns / 1ps
// Response channel of the transmit packet queue: valid, ready and one result item.
// No dependencies.
interface tpq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] decision;
    logic [7:0] read_byte;
    logic [8:0] packet_length;
    logic [3:0] queue_count;

    modport source (
        output valid, status, decision, read_byte, packet_length, queue_count,
        input  ready
    );
    modport sink (
        input  valid, status, decision, read_byte, packet_length, queue_count,
        output ready
    );
endinterface

// File: rtl/tpq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the transmit packet queue: sequences fetch, evaluation,
// head reload and delivery of each item. Depends on tpq_pkg.
module tpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  tpq_pkg::tpq_stat_t stat,
    output tpq_pkg::tpq_ctrl_t ctrl
);

    tpq_pkg::tpq_state_t state_reg;
    tpq_pkg::tpq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = tpq_pkg::ST_FETCH;
                end
            end
            tpq_pkg::ST_FETCH:
            begin
                if (stat.is_push && !stat.is_last)
                begin
                    state_next = tpq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tpq_pkg::ST_EVAL;
                end
            end
            tpq_pkg::ST_EVAL:
            begin
                if (stat.pop_nonempty)
                begin
                    state_next = tpq_pkg::ST_RELOAD;
                end
                else
                begin
                    state_next = tpq_pkg::ST_DELIVER;
                end
            end
            tpq_pkg::ST_RELOAD:
            begin
                state_next = tpq_pkg::ST_RELEN;
            end
            tpq_pkg::ST_RELEN:
            begin
                state_next = tpq_pkg::ST_DELIVER;
            end
            tpq_pkg::ST_DELIVER:
            begin
                if (stat.out_free)
                begin
                    state_next = tpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            tpq_pkg::ST_IDLE:
            begin
                ctrl.ready     = 1'b1;
                ctrl.take_item = req_valid;
            end
            tpq_pkg::ST_FETCH:
            begin
                ctrl.fetch = 1'b1;
            end
            tpq_pkg::ST_EVAL:
            begin
                ctrl.evaluate = 1'b1;
            end
            tpq_pkg::ST_RELOAD:
            begin
                ctrl = '0;
            end
            tpq_pkg::ST_RELEN:
            begin
                ctrl.capture_len = 1'b1;
            end
            tpq_pkg::ST_DELIVER:
            begin
                ctrl.deliver = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// File: rtl/tpq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the transmit packet queue: configuration registers, packet byte
// memory, slot table, ring pointers and the output register. Depends on tpq_pkg.
module tpq_datapath #(
    parameter int DEPTH     = 8,
    parameter int PKT_BYTES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [1:0]                       req_cmd,
    input  logic [7:0]                       req_data_byte,
    input  logic                             req_last_byte,
    input  logic [7:0]                       req_byte_index,
    input  logic [31:0]                      req_now_ms,
    input  logic                             req_tx_busy,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic [1:0]                       rsp_status,
    output logic [1:0]                       rsp_decision,
    output logic [7:0]                       rsp_read_byte,
    output logic [8:0]                       rsp_packet_length,
    output logic [3:0]                       rsp_queue_count,
    input  tpq_pkg::tpq_ctrl_t               ctrl,
    output tpq_pkg::tpq_stat_t               stat
);

    localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LEN_W     = $clog2(PKT_BYTES + 1);
    localparam int INC_W     = $clog2(PKT_BYTES + 2);
    localparam int MEM_DEPTH = DEPTH * PKT_BYTES;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CALC_W    = ADDR_W + 9;

    localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [INC_W-1:0] PKT_I   = INC_W'(PKT_BYTES);
    localparam logic [7:0]       DEPTH_8 = 8'(DEPTH);

    // Control state.
    logic [SLOT_W-1:0] head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [INC_W-1:0]  inc_reg;
    logic              out_valid_reg;
    logic [3:0]        queue_limit_reg;
    logic [31:0]       ttl_reg;
    logic [31:0]       timeout_reg;

    // Latched item.
    logic [1:0]  item_cmd_reg;
    logic [7:0]  item_data_reg;
    logic        item_last_reg;
    logic [7:0]  item_idx_reg;
    logic [31:0] item_now_reg;
    logic        item_busy_reg;

    logic [LEN_W-1:0] head_len_reg;
    logic [1:0]       res_status_reg;
    logic [1:0]       res_decision_reg;
    logic [7:0]       res_rbyte_reg;
    logic [1:0]       res_status_next;
    logic [1:0]       res_decision_next;
    logic [7:0]       res_rbyte_next;

    logic [1:0] out_status_reg;
    logic [1:0] out_decision_reg;
    logic [7:0] out_rbyte_reg;
    logic [8:0] out_plen_reg;
    logic [3:0] out_count_reg;

    // Packet byte memory, single port.
    logic [7:0]        pkt_mem [MEM_DEPTH];
    logic [7:0]        pkt_rd_reg;
    logic              pkt_we;
    logic [ADDR_W-1:0] pkt_addr;

    // Slot table, one write port and one read port at the head.
    logic [LEN_W-1:0] meta_len_mem    [DEPTH];
    logic [31:0]      meta_qtime_mem  [DEPTH];
    logic [31:0]      meta_wstart_mem [DEPTH];
    logic             meta_wait_mem   [DEPTH];
    logic [LEN_W-1:0] meta_len_rd_reg;
    logic [31:0]      meta_qtime_rd_reg;
    logic [31:0]      meta_wstart_rd_reg;
    logic             meta_wait_rd_reg;
    logic             meta_we;
    logic [SLOT_W-1:0] meta_waddr;
    logic [LEN_W-1:0] meta_len_wd;
    logic [31:0]      meta_qtime_wd;
    logic [31:0]      meta_wstart_wd;
    logic             meta_wait_wd;

    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    tail_wrap;
    logic [SLOT_W-1:0] tail_slot;
    logic [CNT_W:0]    head_inc;
    logic [SLOT_W-1:0] head_after_pop;
    logic [7:0]        limit_in;
    logic [7:0]        limit_eff;
    logic              at_limit;
    logic              store_ok;
    logic              inc_over;
    logic              is_empty;
    logic              is_push;
    logic              commit;
    logic              decide_upd;
    logic              out_free;
    logic [CALC_W-1:0] wr_addr_full;
    logic [CALC_W-1:0] rd_addr_full;
    logic [31:0]       age;
    logic [31:0]       wait_from;
    logic [31:0]       waited;
    logic              expired;
    logic              timed_out;
    logic              idx_in_range;
    logic [31:0]       head_len_ext;
    logic [31:0]       count_ext;

    assign is_push  = (item_cmd_reg == tpq_pkg::CMD_PUSH);
    assign is_empty = (count_reg == '0);
    assign out_free = !out_valid_reg || rsp_ready;

    assign tail_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= DEPTH_X) ? (tail_sum - DEPTH_X) : tail_sum;
    assign tail_slot = tail_wrap[SLOT_W-1:0];

    assign head_inc       = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(1);
    assign head_after_pop = (head_inc == DEPTH_X) ? '0 : head_inc[SLOT_W-1:0];

    assign limit_in  = 8'(queue_limit_reg);
    assign limit_eff = (limit_in == 8'd0) ? 8'd1 :
                       ((limit_in > DEPTH_8) ? DEPTH_8 : limit_in);
    assign at_limit  = (8'(count_reg) >= limit_eff);

    assign store_ok = (count_reg < DEPTH_C) && (inc_reg < PKT_I);
    assign inc_over = (inc_reg > PKT_I);

    assign wr_addr_full = CALC_W'(tail_slot) * CALC_W'(PKT_BYTES) + CALC_W'(inc_reg);
    assign rd_addr_full = CALC_W'(head_reg) * CALC_W'(PKT_BYTES) + CALC_W'(item_idx_reg);

    assign pkt_we   = ctrl.fetch && is_push && store_ok;
    assign pkt_addr = is_push ? wr_addr_full[ADDR_W-1:0] : rd_addr_full[ADDR_W-1:0];

    assign age       = item_now_reg - meta_qtime_rd_reg;
    assign expired   = (ttl_reg != 32'd0) && (age >= ttl_reg);
    assign wait_from = meta_wait_rd_reg ? meta_wstart_rd_reg : item_now_reg;
    assign waited    = item_now_reg - wait_from;
    assign timed_out = (waited >= timeout_reg);

    assign head_len_ext = 32'(head_len_reg);
    assign count_ext    = 32'(count_reg);
    assign idx_in_range = (32'(item_idx_reg) < head_len_ext) &&
                          (32'(item_idx_reg) < 32'(PKT_BYTES));

    assign commit     = ctrl.evaluate && is_push && !inc_over && !at_limit;
    assign decide_upd = ctrl.evaluate && (item_cmd_reg == tpq_pkg::CMD_DECIDE) &&
                        !is_empty && !expired;

    assign meta_we        = commit || decide_upd;
    assign meta_waddr     = commit ? tail_slot : head_reg;
    assign meta_len_wd    = commit ? LEN_W'(inc_reg) : meta_len_rd_reg;
    assign meta_qtime_wd  = commit ? item_now_reg : meta_qtime_rd_reg;
    assign meta_wstart_wd = (commit || !item_busy_reg) ? 32'd0 : wait_from;
    assign meta_wait_wd   = !commit && item_busy_reg;

    assign stat.is_push      = is_push;
    assign stat.is_last      = item_last_reg;
    assign stat.pop_nonempty = (item_cmd_reg == tpq_pkg::CMD_POP) && !is_empty;
    assign stat.out_free     = out_free;

    always_comb
    begin
        res_status_next   = tpq_pkg::STATUS_OK;
        res_decision_next = tpq_pkg::DECISION_SEND;
        res_rbyte_next    = 8'd0;
        if (is_push)
        begin
            if (inc_over)
            begin
                res_status_next = tpq_pkg::STATUS_FORMAT_ERR;
            end
            else if (at_limit)
            begin
                res_status_next = tpq_pkg::STATUS_NO_SPACE;
            end
        end
        else if (is_empty)
        begin
            res_status_next = tpq_pkg::STATUS_EMPTY;
            if (item_cmd_reg == tpq_pkg::CMD_DECIDE)
            begin
                res_decision_next = tpq_pkg::DECISION_DROP;
            end
        end
        else if (item_cmd_reg == tpq_pkg::CMD_DECIDE)
        begin
            if (expired)
            begin
                res_decision_next = tpq_pkg::DECISION_DROP;
            end
            else if (item_busy_reg)
            begin
                res_decision_next = timed_out ? tpq_pkg::DECISION_DROP
                                              : tpq_pkg::DECISION_WAIT;
            end
        end
        else if (item_cmd_reg == tpq_pkg::CMD_READ)
        begin
            res_rbyte_next = idx_in_range ? pkt_rd_reg : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_we)
        begin
            pkt_mem[pkt_addr] <= item_data_reg;
        end
        pkt_rd_reg <= pkt_mem[pkt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_len_mem[meta_waddr]    <= meta_len_wd;
            meta_qtime_mem[meta_waddr]  <= meta_qtime_wd;
            meta_wstart_mem[meta_waddr] <= meta_wstart_wd;
            meta_wait_mem[meta_waddr]   <= meta_wait_wd;
        end
        meta_len_rd_reg    <= meta_len_mem[head_reg];
        meta_qtime_rd_reg  <= meta_qtime_mem[head_reg];
        meta_wstart_rd_reg <= meta_wstart_mem[head_reg];
        meta_wait_rd_reg   <= meta_wait_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            count_reg       <= '0;
            inc_reg         <= '0;
            out_valid_reg   <= 1'b0;
            queue_limit_reg <= tpq_pkg::QUEUE_LIMIT_RESET;
            ttl_reg         <= tpq_pkg::TTL_RESET;
            timeout_reg     <= tpq_pkg::BUSY_TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tpq_pkg::CFG_QUEUE_LIMIT)
                begin
                    queue_limit_reg <= cfg_data[3:0];
                end
                else if (cfg_index == tpq_pkg::CFG_TTL_MS)
                begin
                    ttl_reg <= cfg_data;
                end
                else if (cfg_index == tpq_pkg::CFG_BUSY_TIMEOUT_MS)
                begin
                    timeout_reg <= cfg_data;
                end
            end
            if (ctrl.fetch && is_push && (inc_reg <= PKT_I))
            begin
                inc_reg <= inc_reg + INC_W'(1);
            end
            if (ctrl.evaluate && is_push)
            begin
                inc_reg <= '0;
                if (commit)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (ctrl.evaluate && stat.pop_nonempty)
            begin
                head_reg  <= head_after_pop;
                count_reg <= count_reg - CNT_W'(1);
            end
            if (ctrl.deliver && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take_item)
        begin
            item_cmd_reg  <= req_cmd;
            item_data_reg <= req_data_byte;
            item_last_reg <= req_last_byte;
            item_idx_reg  <= req_byte_index;
            item_now_reg  <= req_now_ms;
            item_busy_reg <= req_tx_busy;
        end
        if (ctrl.evaluate)
        begin
            res_status_reg   <= res_status_next;
            res_decision_reg <= res_decision_next;
            res_rbyte_reg    <= res_rbyte_next;
            if (commit && is_empty)
            begin
                head_len_reg <= LEN_W'(inc_reg);
            end
        end
        if (ctrl.capture_len)
        begin
            head_len_reg <= meta_len_rd_reg;
        end
        if (ctrl.deliver && out_free)
        begin
            out_status_reg   <= res_status_reg;
            out_decision_reg <= res_decision_reg;
            out_rbyte_reg    <= res_rbyte_reg;
            out_plen_reg     <= is_empty ? 9'd0 : head_len_ext[8:0];
            out_count_reg    <= count_ext[3:0];
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_decision      = out_decision_reg;
    assign rsp_read_byte     = out_rbyte_reg;
    assign rsp_packet_length = out_plen_reg;
    assign rsp_queue_count   = out_count_reg;

endmodule

// File: rtl/tx_packet_queue_with_aging.sv
`timescale 1ns / 1ps
// Top level of the transmit packet queue with aging: joins controller and datapath
// to the request and response channels. Depends on tpq_pkg, tpq_in_if, tpq_out_if,
// tpq_ctrl and tpq_datapath.
//
// A ring of DEPTH packet slots of PKT_BYTES bytes each, holding at most
// queue_limit packets (a limit of 0 acts as 1, one above DEPTH as DEPTH). One
// item is handled at a time: a push byte that is not the last is accepted, then
// written into the single-port byte memory; a final push, decide or read is
// fetched from the registered byte memory and slot table reads, evaluated and
// delivered to the output register; a pop on a non-empty queue also reads the
// new head's length back from the slot table. A stalled result holds off the
// next item. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce it.
module tx_packet_queue_with_aging #(
    parameter int DEPTH     = 8,
    parameter int PKT_BYTES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpq_pkg::CFG_DATA_W-1:0] cfg_data,
    tpq_in_if.sink                         request,
    tpq_out_if.source                      response
);

    tpq_pkg::tpq_ctrl_t ctrl;
    tpq_pkg::tpq_stat_t stat;

    assign request.ready = ctrl.ready;

    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tpq_datapath #(
        .DEPTH     (DEPTH),
        .PKT_BYTES (PKT_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .req_cmd           (request.cmd),
        .req_data_byte     (request.data_byte),
        .req_last_byte     (request.last_byte),
        .req_byte_index    (request.byte_index),
        .req_now_ms        (request.now_ms),
        .req_tx_busy       (request.tx_busy),
        .rsp_ready         (response.ready),
        .rsp_valid         (response.valid),
        .rsp_status        (response.status),
        .rsp_decision      (response.decision),
        .rsp_read_byte     (response.read_byte),
        .rsp_packet_length (response.packet_length),
        .rsp_queue_count   (response.queue_count),
        .ctrl              (ctrl),
        .stat              (stat)
    );

endmodule

// File: rtl/tpq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the transmit packet queue, bound to the top level.
// Depends on tpq_pkg and tx_packet_queue_with_aging.
module tpq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [1:0] rsp_decision,
    input logic [7:0] rsp_read_byte,
    input logic [8:0] rsp_packet_length,
    input logic [3:0] rsp_queue_count
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
            $stable({rsp_status, rsp_decision, rsp_read_byte,
                     rsp_packet_length, rsp_queue_count}))
        else $error("response changed while stalled");

    // Items are handled one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while the previous item is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == tpq_pkg::STATUS_EMPTY) |->
            (rsp_queue_count == 4'd0) && (rsp_packet_length == 9'd0))
        else $error("empty status reported with packets held");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == tpq_pkg::STATUS_FORMAT_ERR) ||
                      (rsp_status == tpq_pkg::STATUS_NO_SPACE)) |->
            (rsp_decision == tpq_pkg::DECISION_SEND) && (rsp_read_byte == 8'd0))
        else $error("push error carries a decision or a read byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_decision == tpq_pkg::DECISION_WAIT) |->
            (rsp_status == tpq_pkg::STATUS_OK))
        else $error("wait decision without ok status");

endmodule

bind tx_packet_queue_with_aging tpq_checker u_tpq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (request.valid),
    .req_ready         (request.ready),
    .rsp_valid         (response.valid),
    .rsp_ready         (response.ready),
    .rsp_status        (response.status),
    .rsp_decision      (response.decision),
    .rsp_read_byte     (response.read_byte),
    .rsp_packet_length (response.packet_length),
    .rsp_queue_count   (response.queue_count)
);

// File: test/tx_packet_queue_with_aging_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tx_packet_queue_with_aging: a directed table, then random
// phases under changing limits, lifetimes and busy timeouts, checked by a model or pinned rows.
// Depends on tpq_pkg, tpq_in_if, tpq_out_if and the block itself.
module tx_packet_queue_with_aging_tb;
    import tpq_pkg::*;

    localparam int DEPTH          = 8;
    localparam int PKT_BYTES      = 256;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 120;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  idx;
        logic [31:0] now;
        logic        busy;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] decision;
        logic [7:0] rbyte;
        logic [8:0] plen;
        logic [3:0] count;
    } rsp_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [1:0]            cmd;
        logic [CFG_IDX_W-1:0]  sel;
        logic [7:0]            data;
        logic                  last;
        logic [7:0]            idx;
        logic [31:0]           now;
        logic                  busy;
        logic [8:0]            plen;
        logic [3:0]            npk;
        logic                  pin;
        rsp_t                  want;
    } row_t;

    // Push rows send plen bytes per packet, npk packets; other rows repeat npk times.
    // A pinned expectation applies to the last item of its row.
    localparam row_t DIRECTED [37] = '{
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd0, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_EMPTY, DECISION_DROP, 8'h00, 9'd0, 4'd0}},
        '{ROW_ITEM, CMD_POP, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd0, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_EMPTY, DECISION_SEND, 8'h00, 9'd0, 4'd0}},
        '{ROW_ITEM, CMD_READ, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'hFF, 32'd0, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_EMPTY, DECISION_SEND, 8'h00, 9'd0, 4'd0}},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'hFF, 1'b1, 8'h00, 32'd0, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd1, 4'd1}},
        '{ROW_ITEM, CMD_READ, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd0, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'hFF, 9'd1, 4'd1}},
        '{ROW_ITEM, CMD_READ, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'hFF, 32'd0, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd1, 4'd1}},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h00, 1'b1, 8'h00, 32'hFFFF_FFFF, 1'b0, 9'd256,
          4'd1, 1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd1, 4'd2}},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h5A, 1'b1, 8'h00, 32'd50, 1'b0, 9'd257, 4'd1,
          1'b1, '{STATUS_FORMAT_ERR, DECISION_SEND, 8'h00, 9'd1, 4'd2}},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd100, 1'b1, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd5099, 1'b1, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd5100, 1'b1, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd5100, 1'b0, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_ITEM, CMD_POP, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd5200, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd256, 4'd1}},
        '{ROW_ITEM, CMD_READ, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'hFF, 32'd5200, 1'b0, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'hFFFF_FFF0, 1'b1, 9'd1,
          4'd1, 1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'h0000_1378, 1'b1, 9'd1,
          4'd1, 1'b0, '0},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h10, 1'b1, 8'h00, 32'd200, 1'b0, 9'd3, 4'd7,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd256, 4'd8}},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h33, 1'b1, 8'h00, 32'd210, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_NO_SPACE, DECISION_SEND, 8'h00, 9'd256, 4'd8}},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h77, 1'b0, 8'h00, 32'd220, 1'b0, 9'd2, 4'd1,
          1'b0, '0},
        '{ROW_ITEM, CMD_POP, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd230, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd3, 4'd7}},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h99, 1'b1, 8'h00, 32'd300, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd3, 4'd8}},
        '{ROW_ITEM, CMD_POP, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd310, 1'b0, 9'd1, 4'd8,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd0, 4'd0}},
        '{ROW_CFG, CMD_PUSH, CFG_TTL_MS, 8'h00, 1'b0, 8'h00, 32'd10, 1'b0, 9'd0, 4'd0,
          1'b0, '0},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h20, 1'b1, 8'h00, 32'd1000, 1'b0, 9'd2, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd2, 4'd1}},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd1009, 1'b0, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd1010, 1'b0, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_CFG, CMD_PUSH, CFG_TTL_MS, 8'h00, 1'b0, 8'h00, 32'hFFFF_FFFF, 1'b0, 9'd0, 4'd0,
          1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd999, 1'b0, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_CFG, CMD_PUSH, CFG_TTL_MS, 8'h00, 1'b0, 8'h00, 32'd0, 1'b0, 9'd0, 4'd0,
          1'b0, '0},
        '{ROW_CFG, CMD_PUSH, CFG_BUSY_TIMEOUT_MS, 8'h00, 1'b0, 8'h00, 32'd0, 1'b0, 9'd0, 4'd0,
          1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd7, 1'b1, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_CFG, CMD_PUSH, CFG_BUSY_TIMEOUT_MS, 8'h00, 1'b0, 8'h00, 32'hFFFF_FFFF, 1'b0, 9'd0,
          4'd0, 1'b0, '0},
        '{ROW_ITEM, CMD_DECIDE, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd6, 1'b1, 9'd1, 4'd1,
          1'b0, '0},
        '{ROW_CFG, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd0, 1'b0, 9'd0, 4'd0,
          1'b0, '0},
        '{ROW_ITEM, CMD_PUSH, CFG_QUEUE_LIMIT, 8'hC3, 1'b1, 8'h00, 32'd20, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_NO_SPACE, DECISION_SEND, 8'h00, 9'd2, 4'd1}},
        '{ROW_ITEM, CMD_POP, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd30, 1'b0, 9'd1, 4'd1,
          1'b1, '{STATUS_OK, DECISION_SEND, 8'h00, 9'd0, 4'd0}},
        '{ROW_CFG, CMD_PUSH, CFG_QUEUE_LIMIT, 8'h00, 1'b0, 8'h00, 32'd15, 1'b0, 9'd0, 4'd0,
          1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tpq_in_if  request_ch ();
    tpq_out_if response_ch ();

    tx_packet_queue_with_aging #(
        .DEPTH     (DEPTH),
        .PKT_BYTES (PKT_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .response  (response_ch)
    );

    always #5 clk = ~clk;

    // Shadow of the queue.
    logic [7:0]  pkt_mem [DEPTH*PKT_BYTES];
    bit          mem_set [DEPTH*PKT_BYTES];
    logic [8:0]  slot_len [DEPTH];
    logic [31:0] slot_stamp [DEPTH];
    logic [31:0] slot_wait_from [DEPTH];
    bit          slot_waiting [DEPTH];
    int unsigned head_slot = 0;
    int unsigned held = 0;
    int unsigned incoming = 0;
    logic [3:0]  limit_reg = QUEUE_LIMIT_RESET;
    logic [31:0] ttl_reg = TTL_RESET;
    logic [31:0] tmo_reg = BUSY_TIMEOUT_RESET;

    rsp_t        expected_rsp [$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit          steady = 1'b0;
    logic [31:0] clock_ms = '0;
    int unsigned bytes_left = 0;

    initial
    begin
        for (int s = 0; s < DEPTH; s++)
        begin
            slot_len[s] = '0;
            slot_stamp[s] = '0;
            slot_wait_from[s] = '0;
        end
    end

    function automatic bit forecast_queue(input req_t r, output rsp_t o);
        int unsigned h;
        int unsigned tail;
        int unsigned eff;
        logic [31:0] waited;
        o = '0;
        h = head_slot;
        eff = (limit_reg == 0) ? 1 : (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
        if (r.cmd == CMD_PUSH)
        begin
            tail = (head_slot + held) % DEPTH;
            if (held < DEPTH && incoming < PKT_BYTES)
            begin
                pkt_mem[tail*PKT_BYTES + incoming] = r.data;
                mem_set[tail*PKT_BYTES + incoming] = 1'b1;
            end
            if (incoming <= PKT_BYTES)
                incoming++;
            if (!r.last)
                return 1'b0;
            if (incoming > PKT_BYTES)
                o.status = STATUS_FORMAT_ERR;
            else if (held >= eff)
                o.status = STATUS_NO_SPACE;
            else
            begin
                slot_len[tail] = 9'(incoming);
                slot_stamp[tail] = r.now;
                slot_wait_from[tail] = '0;
                slot_waiting[tail] = 1'b0;
                held++;
            end
            incoming = 0;
        end
        else if (held == 0)
        begin
            o.status = STATUS_EMPTY;
            if (r.cmd == CMD_DECIDE)
                o.decision = DECISION_DROP;
        end
        else if (r.cmd == CMD_DECIDE)
        begin
            if (ttl_reg != 0 && (r.now - slot_stamp[h]) >= ttl_reg)
                o.decision = DECISION_DROP;
            else if (r.busy)
            begin
                if (!slot_waiting[h])
                begin
                    slot_waiting[h] = 1'b1;
                    slot_wait_from[h] = r.now;
                end
                waited = r.now - slot_wait_from[h];
                o.decision = (waited >= tmo_reg) ? DECISION_DROP : DECISION_WAIT;
            end
            else
            begin
                slot_waiting[h] = 1'b0;
                slot_wait_from[h] = '0;
                o.decision = DECISION_SEND;
            end
        end
        else if (r.cmd == CMD_POP)
        begin
            slot_len[h] = '0;
            slot_stamp[h] = '0;
            slot_wait_from[h] = '0;
            slot_waiting[h] = 1'b0;
            head_slot = (h + 1) % DEPTH;
            held--;
        end
        else if (r.idx < slot_len[h])
            o.rbyte = pkt_mem[h*PKT_BYTES + r.idx];
        o.plen = (held != 0) ? slot_len[head_slot] : '0;
        o.count = 4'(held);
        return 1'b1;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_span(input int unsigned sel);
        case (sel)
            0: return $urandom_range(1, 40);
            1: return '0;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 4);
        else if (roll < 95)
            return $urandom_range(5, 16);
        else if (roll < 99)
            return $urandom_range(17, 64);
        return $urandom_range(250, 258);
    endfunction

    // Bytes skipped while every slot was full are never read back.
    function automatic logic [7:0] read_index();
        int unsigned len;
        int unsigned base;
        int unsigned k;
        if (held == 0)
            return 8'($urandom);
        len = slot_len[head_slot];
        base = head_slot * PKT_BYTES;
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, len - 1);
        while (k < len && !mem_set[base + k])
            k++;
        return 8'(k);
    endfunction

    function automatic req_t next_random_item();
        req_t r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            clock_ms += $urandom_range(0, 3);
        else if (roll < 90)
            clock_ms += $urandom_range(4, 20);
        else if (roll < 99)
            clock_ms += $urandom_range(21, 100);
        else
            clock_ms = $urandom;
        r.data = 8'($urandom);
        r.idx = 8'($urandom);
        r.last = 1'($urandom);
        r.busy = ($urandom_range(0, 9) < 6);
        r.now = clock_ms;
        if (bytes_left == 0 && $urandom_range(0, 3) == 0)
            bytes_left = pick_length();
        if (bytes_left > 0 && $urandom_range(0, 19) != 0)
        begin
            r.cmd = CMD_PUSH;
            bytes_left--;
            r.last = (bytes_left == 0);
            if ($urandom_range(0, 99) == 0)
            begin
                r.last = 1'b1;
                bytes_left = 0;
            end
        end
        else
        begin
            roll = $urandom_range(0, 59);
            if (roll < 25)
                r.cmd = CMD_DECIDE;
            else if (roll < 40)
                r.cmd = CMD_POP;
            else
            begin
                r.cmd = CMD_READ;
                r.idx = read_index();
            end
        end
        return r;
    endfunction

    task automatic send_item(input req_t r, input bit pinned, input rsp_t pinned_rsp);
        int unsigned gap;
        rsp_t predicted;
        gap = steady ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            request_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_ch.cmd        = r.cmd;
        request_ch.data_byte  = r.data;
        request_ch.last_byte  = r.last;
        request_ch.byte_index = r.idx;
        request_ch.now_ms     = r.now;
        request_ch.tx_busy    = r.busy;
        request_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (!request_ch.ready);
        if (forecast_queue(r, predicted))
            expected_rsp.push_back(pinned ? pinned_rsp : predicted);
    endtask

    task automatic settle_queue();
        @(negedge clk);
        request_ch.valid = 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [31:0] value);
        settle_queue();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = value;
        case (sel)
            CFG_QUEUE_LIMIT:     limit_reg = value[3:0];
            CFG_TTL_MS:          ttl_reg = value;
            CFG_BUSY_TIMEOUT_MS: tmo_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t ns: result with none expected, got status %0d count %0d",
                         $time, response_ch.status, response_ch.queue_count);
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("status", 9'(want.status), 9'(response_ch.status));
                check_field("decision", 9'(want.decision), 9'(response_ch.decision));
                check_field("read_byte", 9'(want.rbyte), 9'(response_ch.read_byte));
                check_field("packet_length", want.plen, response_ch.packet_length);
                check_field("queue_count", 9'(want.count), 9'(response_ch.queue_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tx_packet_queue_with_aging: mismatch");
            $finish;
        end
    end

    initial
    begin : ready_gen
        int unsigned hold;
        hold = 0;
        response_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                response_ch.ready = 1'b0;
                hold--;
            end
            else
            begin
                response_ch.ready = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    hold = idle_gap();
            end
        end
    end

    initial
    begin : stimulus
        row_t        row;
        req_t        item;
        int unsigned reps;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        request_ch.valid      = 1'b0;
        request_ch.cmd        = CMD_PUSH;
        request_ch.data_byte  = '0;
        request_ch.last_byte  = 1'b0;
        request_ch.byte_index = '0;
        request_ch.now_ms     = '0;
        request_ch.tx_busy    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[n])
        begin
            row = DIRECTED[n];
            if (row.kind == ROW_CFG)
                write_reg(row.sel, row.now);
            else
            begin
                reps = (row.cmd == CMD_PUSH) ? row.plen : 1;
                for (int pk = 0; pk < row.npk; pk++)
                begin
                    for (int b = 0; b < reps; b++)
                    begin
                        item.cmd  = row.cmd;
                        item.data = row.data + 8'(b);
                        item.last = row.last && (b == reps - 1);
                        item.idx  = row.idx;
                        item.now  = row.now;
                        item.busy = row.busy;
                        send_item(item, row.pin && (pk == row.npk - 1) && (b == reps - 1),
                                  row.want);
                    end
                end
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_QUEUE_LIMIT, (p < 3) ? ((p == 0) ? 32'd1 : (p == 1) ? 32'd15 : 32'd0)
                                               : $urandom_range(0, 15));
            write_reg(CFG_TTL_MS, pick_span(p % 4));
            write_reg(CFG_BUSY_TIMEOUT_MS, pick_span((p + 2) % 4));
            steady = (p % 3 == 2);
            clock_ms = (p % 2 == 1) ? $urandom : 32'hFFFF_FFC0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(next_random_item(), 1'b0, '0);
        end

        settle_queue();
        if (errors == 0)
            $display("tx_packet_queue_with_aging: match");
        else
            $display("tx_packet_queue_with_aging: mismatch");
        $finish;
    end
endmodule

// File: tx_packet_queue_with_aging.f
rtl/tpq_pkg.sv
rtl/tpq_in_if.sv
rtl/tpq_out_if.sv
rtl/tpq_ctrl.sv
rtl/tpq_datapath.sv
rtl/tx_packet_queue_with_aging.sv
rtl/tpq_checker.sv
test/tx_packet_queue_with_aging_tb.sv
